### src/dcfh_pkg.sv
`default_nettype none

package dcfh_pkg;

    localparam int PIX_W           = 8;
    localparam int COUNT_W         = 17;
    localparam int PCT_W           = 7;
    localparam int TOTAL_W         = COUNT_W + 2;
    localparam int PROD_W          = TOTAL_W + PCT_W;
    localparam int DIFF_W          = COUNT_W + 1;
    localparam int SCALED_W        = PROD_W + 2;
    localparam int INDEX_W         = 7;
    localparam int HASH_W          = 64;
    localparam int COLOR_W         = 3;
    localparam int PCT_SCALE       = 100;
    localparam int RUN_LENGTH      = 16;
    localparam int PATTERN_FRAMES  = 64;
    localparam int FRAME_INDEX_MAX = 64;

    typedef enum logic [COLOR_W-1:0] {
        COLOR_RED   = 3'd0,
        COLOR_GREEN = 3'd1,
        COLOR_BLUE  = 3'd2,
        COLOR_LEVEL = 3'd3,
        COLOR_NONE  = 3'd4
    } color_t;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

### src/dominant_color_frame_hash_core.sv
`default_nettype none

// Channel   Handshake                  Words
// pixel     pix_valid / pix_stall      blue, green, red, last_of_frame, last_of_video
// result    res_valid / res_stall      frame_color, frame_number, hash_value, video_done
// config    min_percent_diff_wr        min_percent_diff
//
// One pixel a cycle is accepted while pix_stall is low; pixels that do not end a frame leave no result.
// A frame end passes through the input register, count snapshot, margin product, and color compare
// and hash update into the result register before it shows on res_valid.
// The four color counters take the next frame's pixels while the decision runs.
// Reset clears counters, frame index, hash, minimum percent setting and all stage valid bits.
// A stalled result holds; the pixel side keeps moving until the stages behind it fill.

module dominant_color_frame_hash_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              min_percent_diff_wr,
    input  wire logic [dcfh_pkg::PCT_W-1:0]        min_percent_diff,
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire logic [dcfh_pkg::PIX_W-1:0]        blue,
    input  wire logic [dcfh_pkg::PIX_W-1:0]        green,
    input  wire logic [dcfh_pkg::PIX_W-1:0]        red,
    input  wire logic                              last_of_frame,
    input  wire logic                              last_of_video,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic [dcfh_pkg::COLOR_W-1:0]           frame_color,
    output logic [dcfh_pkg::INDEX_W-1:0]           frame_number,
    output logic [dcfh_pkg::HASH_W-1:0]            hash_value,
    output logic                                   video_done
);
    import dcfh_pkg::*;

    localparam logic [INDEX_W-1:0] LAST_PATTERN = INDEX_W'(PATTERN_FRAMES - 1);
    localparam logic [INDEX_W-1:0] PATTERN_LEN  = INDEX_W'(PATTERN_FRAMES);
    localparam logic [INDEX_W-1:0] INDEX_MAX    = INDEX_W'(FRAME_INDEX_MAX);

    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c == '1) ? c : c + count_t'(1);
    endfunction

    logic [PCT_W-1:0]   pct_reg;

    logic               s0_v_reg;
    logic [PIX_W-1:0]   s0_blue_reg;
    logic [PIX_W-1:0]   s0_green_reg;
    logic [PIX_W-1:0]   s0_red_reg;
    logic               s0_end_reg;
    logic               s0_video_reg;

    count_t             blue_cnt_reg;
    count_t             green_cnt_reg;
    count_t             red_cnt_reg;
    count_t             level_cnt_reg;
    count_t             blue_cnt_next;
    count_t             green_cnt_next;
    count_t             red_cnt_next;
    count_t             level_cnt_next;

    logic               s1_v_reg;
    count_t             s1_blue_reg;
    count_t             s1_green_reg;
    count_t             s1_red_reg;
    count_t             s1_level_reg;
    logic               s1_video_reg;

    logic               s2_v_reg;
    logic [PROD_W-1:0]  s2_prod_reg;
    logic               s2_level_reg;
    logic signed [DIFF_W-1:0] s2_br_reg;
    logic signed [DIFF_W-1:0] s2_bg_reg;
    logic signed [DIFF_W-1:0] s2_gr_reg;
    logic               s2_video_reg;

    logic               out_v_reg;
    color_t             out_color_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [HASH_W-1:0]  out_hash_reg;
    logic               out_video_reg;

    logic [INDEX_W-1:0] frame_idx_reg;
    logic [HASH_W-1:0]  hash_reg;

    logic out_load;
    logic s2_free;
    logic s1_move;
    logic s1_free;
    logic s0_move;
    logic s0_free;
    logic pix_take;

    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  product;

    logic signed [SCALED_W-1:0] margin_s;
    logic signed [SCALED_W-1:0] sc_br;
    logic signed [SCALED_W-1:0] sc_bg;
    logic signed [SCALED_W-1:0] sc_gr;
    logic signed [SCALED_W-1:0] sc_gb;
    logic signed [SCALED_W-1:0] sc_rg;
    logic signed [SCALED_W-1:0] sc_rb;
    color_t             color;
    logic [1:0]         expect_code;
    logic [5:0]         bit_pos;
    logic               hit;
    logic [HASH_W-1:0]  hash_next;

    assign out_load = s2_v_reg && (!out_v_reg || !res_stall);
    assign s2_free  = !s2_v_reg || out_load;
    assign s1_move  = s1_v_reg && s2_free;
    assign s1_free  = !s1_v_reg || s1_move;
    assign s0_move  = s0_v_reg && (!s0_end_reg || s1_free);
    assign s0_free  = !s0_v_reg || s0_move;
    assign pix_stall = !s0_free;
    assign pix_take  = pix_valid && s0_free;

    always_comb
    begin
        blue_cnt_next  = blue_cnt_reg;
        green_cnt_next = green_cnt_reg;
        red_cnt_next   = red_cnt_reg;
        level_cnt_next = level_cnt_reg;
        if (s0_blue_reg > s0_red_reg && s0_blue_reg > s0_green_reg)
        begin
            blue_cnt_next = sat_inc(blue_cnt_reg);
        end
        else if (s0_green_reg > s0_red_reg && s0_green_reg > s0_blue_reg)
        begin
            green_cnt_next = sat_inc(green_cnt_reg);
        end
        else if (s0_red_reg > s0_green_reg && s0_red_reg > s0_blue_reg)
        begin
            red_cnt_next = sat_inc(red_cnt_reg);
        end
        else
        begin
            level_cnt_next = sat_inc(level_cnt_reg);
        end
    end

    assign total = TOTAL_W'(s1_blue_reg) + TOTAL_W'(s1_green_reg)
                 + TOTAL_W'(s1_red_reg) + TOTAL_W'(s1_level_reg);
    assign product = PROD_W'(total) * PROD_W'(pct_reg);

    always_comb
    begin
        margin_s = $signed({2'b00, s2_prod_reg});
        sc_br = SCALED_W'(s2_br_reg) * SCALED_W'(PCT_SCALE);
        sc_bg = SCALED_W'(s2_bg_reg) * SCALED_W'(PCT_SCALE);
        sc_gr = SCALED_W'(s2_gr_reg) * SCALED_W'(PCT_SCALE);
        sc_gb = -sc_bg;
        sc_rg = -sc_gr;
        sc_rb = -sc_br;
        if (s2_level_reg)
        begin
            color = COLOR_LEVEL;
        end
        else if (sc_br > margin_s && sc_bg > margin_s)
        begin
            color = COLOR_BLUE;
        end
        else if (sc_gr > margin_s && sc_gb > margin_s)
        begin
            color = COLOR_GREEN;
        end
        else if (sc_rg > margin_s && sc_rb > margin_s)
        begin
            color = COLOR_RED;
        end
        else
        begin
            color = COLOR_NONE;
        end
    end

    always_comb
    begin
        expect_code = 2'((frame_idx_reg / RUN_LENGTH) & INDEX_W'(3));
        bit_pos     = 6'(LAST_PATTERN - frame_idx_reg);
        hit = (frame_idx_reg < PATTERN_LEN)
           && (color == color_t'({1'b0, expect_code}));
        hash_next = hash_reg;
        if (hit)
        begin
            hash_next[bit_pos] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg       <= '0;
            s0_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
            blue_cnt_reg  <= '0;
            green_cnt_reg <= '0;
            red_cnt_reg   <= '0;
            level_cnt_reg <= '0;
            frame_idx_reg <= '0;
            hash_reg      <= '0;
        end
        else
        begin
            if (min_percent_diff_wr)
            begin
                pct_reg <= min_percent_diff;
            end

            if (pix_take)
            begin
                s0_v_reg <= 1'b1;
            end
            else if (s0_move)
            begin
                s0_v_reg <= 1'b0;
            end

            if (s0_move)
            begin
                if (s0_end_reg)
                begin
                    blue_cnt_reg  <= '0;
                    green_cnt_reg <= '0;
                    red_cnt_reg   <= '0;
                    level_cnt_reg <= '0;
                end
                else
                begin
                    blue_cnt_reg  <= blue_cnt_next;
                    green_cnt_reg <= green_cnt_next;
                    red_cnt_reg   <= red_cnt_next;
                    level_cnt_reg <= level_cnt_next;
                end
            end

            if (s0_move && s0_end_reg)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_v_reg <= 1'b0;
            end

            if (s1_move)
            begin
                s2_v_reg <= 1'b1;
            end
            else if (out_load)
            begin
                s2_v_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_v_reg <= 1'b1;
                if (s2_video_reg)
                begin
                    frame_idx_reg <= '0;
                    hash_reg      <= '0;
                end
                else
                begin
                    hash_reg <= hash_next;
                    if (frame_idx_reg < INDEX_MAX)
                    begin
                        frame_idx_reg <= frame_idx_reg + INDEX_W'(1);
                    end
                end
            end
            else if (!res_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s0_blue_reg  <= blue;
            s0_green_reg <= green;
            s0_red_reg   <= red;
            s0_end_reg   <= last_of_frame || last_of_video;
            s0_video_reg <= last_of_video;
        end
        if (s0_move && s0_end_reg)
        begin
            s1_blue_reg  <= blue_cnt_next;
            s1_green_reg <= green_cnt_next;
            s1_red_reg   <= red_cnt_next;
            s1_level_reg <= level_cnt_next;
            s1_video_reg <= s0_video_reg;
        end
        if (s1_move)
        begin
            s2_prod_reg  <= product;
            s2_level_reg <= (s1_level_reg >= s1_blue_reg) && (s1_level_reg >= s1_green_reg)
                         && (s1_level_reg >= s1_red_reg);
            s2_br_reg    <= $signed({1'b0, s1_blue_reg}) - $signed({1'b0, s1_red_reg});
            s2_bg_reg    <= $signed({1'b0, s1_blue_reg}) - $signed({1'b0, s1_green_reg});
            s2_gr_reg    <= $signed({1'b0, s1_green_reg}) - $signed({1'b0, s1_red_reg});
            s2_video_reg <= s1_video_reg;
        end
        if (out_load)
        begin
            out_color_reg <= color;
            out_index_reg <= frame_idx_reg;
            out_hash_reg  <= hash_next;
            out_video_reg <= s2_video_reg;
        end
    end

    assign res_valid    = out_v_reg;
    assign frame_color  = out_color_reg;
    assign frame_number = out_index_reg;
    assign hash_value   = out_hash_reg;
    assign video_done   = out_video_reg;

`ifndef SYNTHESIS
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_idx_reg <= INDEX_MAX)
        else $error("frame index past its limit");

    a_video_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && s2_video_reg |=> frame_idx_reg == '0 && hash_reg == '0)
        else $error("video end did not clear index and hash");

    a_hash_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && s2_video_reg) |=> (hash_reg & $past(hash_reg)) == $past(hash_reg))
        else $error("hash bit lost within a video");

    a_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
        s0_move && s0_end_reg |-> s1_free)
        else $error("frame end entered a busy snapshot stage");
`endif

endmodule

`default_nettype wire
